@@ sv/blg_pkg.sv @@
// ----------------------------------------------------------------------------
// blg_pkg
// Types and fixed constants shared by the battery level gauge modules.
// ----------------------------------------------------------------------------
package blg_pkg;

   localparam int SUM_W  = 17;
   localparam int CNT_W  = 5;
   localparam int SMP_W  = 12;
   localparam int AVG_W  = 12;
   localparam int LVL_W  = 7;
   localparam int BAND_W = 4;

   // Scaled voltage p = avg * 155 (that is avg * 6200 / 40)
   localparam int P_W = 20;
   localparam logic [P_W-1:0] P_SCALE     = 20'd155;
   localparam logic [P_W-1:0] P_FULL      = 20'd430080;  // 4200 mV
   localparam logic [P_W-1:0] P_EMPTY     = 20'd337920;  // 3300 mV
   localparam logic [P_W-1:0] P_KNEE      = 20'd373760;  // 3650 mV
   localparam logic [P_W-1:0] P_HIGH_BASE = 20'd363520;  // 3550 mV
   localparam logic [P_W-1:0] P_LOW_BASE  = 20'd327680;  // 3200 mV

   // Upper segment: (p - P_HIGH_BASE) / 832 = ((.) >> 6) / 13
   // Lower segment: (p - P_LOW_BASE) / 2304 = ((.) >> 8) / 9
   localparam int Y_W = 11;
   localparam int RH_W = 23;
   localparam logic [RH_W-1:0] RECIP_13 = 23'd2521;   // ceil(2^15 / 13)
   localparam int RECIP_13_SHIFT = 15;
   localparam int RL_W = 20;
   localparam logic [RL_W-1:0] RECIP_9 = 20'd456;     // ceil(2^12 / 9)
   localparam int RECIP_9_SHIFT = 12;

   localparam logic [LVL_W-1:0] LVL_FULL       = 7'd100;
   localparam logic [LVL_W-1:0] LVL_EMPTY      = 7'd0;
   localparam logic [LVL_W-1:0] LVL_HIGH_START = 7'd20;

   localparam logic [BAND_W-1:0] HOLD_BAND_RESET = 4'd4;

   // Group average: sum * ceil(2^22 / SAMPLES) >> 22 is exact for sums below 2^17
   localparam int AVG_SHIFT = 22;
   localparam int RECIP_W   = 23;
   localparam int PROD_W    = SUM_W + RECIP_W;

   typedef enum logic [1:0] {
      SEG_EMPTY,
      SEG_LOW,
      SEG_HIGH,
      SEG_FULL
   } seg_type;

endpackage

@@ sv/battery_level_gauge_core.sv @@
// ----------------------------------------------------------------------------
// battery_level_gauge_core
// Battery ADC samples in, whole-percent charge level out.
//
// The req_ channel carries one 12-bit ADC sample per item. Every SAMPLES
// items form a group; at the last item of a group the rsp_ channel later
// delivers one item, the level in percent (0..100) after the hold band.
// The csr_ port writes hold_band; write it only while the block is idle.
//
// Throughput: one sample per cycle while req_stall is low. A group result
// reaches the result register through the queue, average, scale,
// classify, divide and hold band stages.
// A two-entry queue of group sums sits between accumulator and pipeline.
//
// A stall on rsp_ freezes the pipeline and holds the result; the queue
// then fills, and req_stall rises only for a group's last sample while
// the queue is full. Reset clears the running sum, count, queue, pipeline,
// previous level (zero) and sets hold_band to 4.
// ----------------------------------------------------------------------------
module battery_level_gauge_core
   import blg_pkg::*;
#(
   parameter int SAMPLES = 20
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [SMP_W-1:0]  req_sample,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [LVL_W-1:0]  rsp_level_percent,
   input  logic              csr_write_enable,
   input  logic [BAND_W-1:0] csr_write_data
);

   logic             push_valid, push_stall;
   logic [SUM_W-1:0] push_sum;
   logic             pop_valid, pop_stall;
   logic [SUM_W-1:0] pop_sum;

   blg_front #(.SAMPLES(SAMPLES)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_sample (req_sample),
      .push_valid (push_valid),
      .push_stall (push_stall),
      .push_sum   (push_sum)
   );

   blg_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_stall (push_stall),
      .push_sum   (push_sum),
      .pop_valid  (pop_valid),
      .pop_stall  (pop_stall),
      .pop_sum    (pop_sum)
   );

   blg_back #(.SAMPLES(SAMPLES)) u_back (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .pop_valid         (pop_valid),
      .pop_stall         (pop_stall),
      .pop_sum           (pop_sum),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_level_percent (rsp_level_percent)
   );

endmodule

@@ sv/blg_front.sv @@
// ----------------------------------------------------------------------------
// blg_front
// Accumulates samples over one group and hands the group sum to the queue.
// ----------------------------------------------------------------------------
module blg_front
   import blg_pkg::*;
#(
   parameter int SAMPLES = 20
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [SMP_W-1:0] req_sample,
   output logic             push_valid,
   input  logic             push_stall,
   output logic [SUM_W-1:0] push_sum
);

   localparam logic [CNT_W-1:0] LAST_COUNT = CNT_W'(SAMPLES - 1);

   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             last;
   logic             accept;
   logic [SUM_W-1:0] sum_next;

   assign last      = (count_ff == LAST_COUNT);
   assign req_stall = last && push_stall;
   assign accept    = req_valid && !req_stall;
   assign sum_next  = sum_ff + SUM_W'(req_sample);

   assign push_valid = accept && last;
   assign push_sum   = sum_next;

   always_comb begin
      sum_in   = sum_ff;
      count_in = count_ff;
      if (accept) begin
         if (last) begin
            sum_in   = '0;
            count_in = '0;
         end else begin
            sum_in   = sum_next;
            count_in = count_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff   <= '0;
         count_ff <= '0;
      end else begin
         sum_ff   <= sum_in;
         count_ff <= count_in;
      end
   end

endmodule

@@ sv/blg_queue.sv @@
// ----------------------------------------------------------------------------
// blg_queue
// Two-entry queue of group sums between the front and the back.
// ----------------------------------------------------------------------------
module blg_queue
   import blg_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_stall,
   input  logic [SUM_W-1:0] push_sum,
   output logic             pop_valid,
   input  logic             pop_stall,
   output logic [SUM_W-1:0] pop_sum
);

   logic [SUM_W-1:0] entry_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       fill_ff, fill_in;
   logic             do_push;
   logic             do_pop;

   assign push_stall = (fill_ff == 2'd2);
   assign pop_valid  = (fill_ff != 2'd0);
   assign pop_sum    = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && !push_stall;
   assign do_pop     = pop_valid && !pop_stall;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      fill_in   = fill_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_sum;
      end
   end

endmodule

@@ sv/blg_back.sv @@
// ----------------------------------------------------------------------------
// blg_back
// Averages a group sum, maps it to a percent, applies the hold band and
// drives the result register.
// ----------------------------------------------------------------------------
module blg_back
   import blg_pkg::*;
#(
   parameter int SAMPLES = 20
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_write_enable,
   input  logic [BAND_W-1:0] csr_write_data,
   input  logic              pop_valid,
   output logic              pop_stall,
   input  logic [SUM_W-1:0]  pop_sum,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [LVL_W-1:0]  rsp_level_percent
);

   localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'(((64'd1 << AVG_SHIFT) + 64'(SAMPLES) - 64'd1) / 64'(SAMPLES));

   logic advance;

   logic [BAND_W-1:0] hold_band_ff, hold_band_in;

   logic              v1_ff, v2_ff, v3_ff, v4_ff;
   logic [PROD_W-1:0] prod1_ff, prod1_in;
   logic [AVG_W-1:0]  avg2;
   logic [P_W-1:0]    p2_ff, p2_in;
   logic [P_W-1:0]    diff_hi, diff_lo;
   seg_type           seg3_ff, seg3_in;
   logic [Y_W-1:0]    y3_ff, y3_in;
   logic [RH_W-1:0]   prod_hi;
   logic [RL_W-1:0]   prod_lo;
   logic [LVL_W-1:0]  lvl4_ff, lvl4_in;
   logic [LVL_W-1:0]  prev_ff, prev_in;
   logic [LVL_W-1:0]  held;
   logic              out_valid_ff, out_valid_in;
   logic [LVL_W-1:0]  out_level_ff, out_level_in;

   assign advance   = !out_valid_ff || !rsp_stall;
   assign pop_stall = !advance;

   assign hold_band_in = csr_write_enable ? csr_write_data : hold_band_ff;

   // average and scaled voltage
   assign prod1_in = PROD_W'(pop_sum) * PROD_W'(RECIP);
   assign avg2     = prod1_ff[AVG_SHIFT +: AVG_W];
   assign p2_in    = P_W'(avg2) * P_SCALE;

   // classify
   assign diff_hi = p2_ff - P_HIGH_BASE;
   assign diff_lo = p2_ff - P_LOW_BASE;

   always_comb begin
      seg3_in = SEG_LOW;
      y3_in   = Y_W'(diff_lo[P_W-1:8]);
      if (p2_ff > P_FULL) begin
         seg3_in = SEG_FULL;
      end else if (p2_ff < P_EMPTY) begin
         seg3_in = SEG_EMPTY;
      end else if (p2_ff > P_KNEE) begin
         seg3_in = SEG_HIGH;
         y3_in   = diff_hi[16:6];
      end
   end

   // divide the segment offset by its constant
   assign prod_hi = RH_W'(y3_ff) * RECIP_13;
   assign prod_lo = RL_W'(y3_ff[7:0]) * RECIP_9;

   always_comb begin
      case (seg3_ff)
         SEG_FULL: lvl4_in = LVL_FULL;
         SEG_HIGH: lvl4_in = prod_hi[RECIP_13_SHIFT +: LVL_W] + LVL_HIGH_START;
         SEG_LOW:  lvl4_in = prod_lo[RECIP_9_SHIFT +: LVL_W];
         default:  lvl4_in = LVL_EMPTY;
      endcase
   end

   // hold back small rises
   always_comb begin
      held = lvl4_ff;
      if ((lvl4_ff > prev_ff) && ((lvl4_ff - prev_ff) < LVL_W'(hold_band_ff)) &&
          (prev_ff != LVL_EMPTY)) begin
         held = prev_ff;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_level_in = out_level_ff;
      prev_in      = prev_ff;
      if (advance) begin
         out_valid_in = v4_ff;
         if (v4_ff) begin
            out_level_in = held;
            prev_in      = held;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_band_ff <= HOLD_BAND_RESET;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
         prev_ff      <= LVL_EMPTY;
      end else begin
         hold_band_ff <= hold_band_in;
         out_valid_ff <= out_valid_in;
         prev_ff      <= prev_in;
         if (advance) begin
            v1_ff <= pop_valid;
            v2_ff <= v1_ff;
            v3_ff <= v2_ff;
            v4_ff <= v3_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      out_level_ff <= out_level_in;
      if (advance) begin
         prod1_ff <= prod1_in;
         p2_ff    <= p2_in;
         seg3_ff  <= seg3_in;
         y3_ff    <= y3_in;
         lvl4_ff  <= lvl4_in;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_level_percent = out_level_ff;

endmodule

@@ sv/battery_level_gauge_checker.sv @@
// ----------------------------------------------------------------------------
// battery_level_gauge_checker
// Port-level checks of the battery level gauge, bound to the top level.
// ----------------------------------------------------------------------------
module battery_level_gauge_checker
   import blg_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input logic [LVL_W-1:0] rsp_level_percent
);

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_level_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_level_percent <= LVL_FULL))
      else $error("level above full scale");

   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("stalled result dropped");

   a_hold_level: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_level_percent))
      else $error("stalled result changed");

endmodule

bind battery_level_gauge_core battery_level_gauge_checker u_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_level_percent (rsp_level_percent)
);

@@ tb/sv/battery_level_gauge_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_battery_level_gauge_checker
// Watches the sample, level and csr ports of the gauge and checks its output.
//
// Keeps its own running group sum, sample count, previous level and hold
// band. At the last sample of each group it forms the average, maps it to
// a percent and applies the hold band, then queues the expected level.
// Every accepted rsp_ item is compared with the oldest queued level.
// ----------------------------------------------------------------------------
module tb_battery_level_gauge_checker
   import blg_pkg::*;
#(
   parameter int SAMPLES = 20
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  logic [SMP_W-1:0]  req_sample,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  logic [LVL_W-1:0]  rsp_level_percent,
   input  logic              csr_write_enable,
   input  logic [BAND_W-1:0] csr_write_data,
   output int                fail_count,
   output int                outstanding
);

   localparam longint unsigned MV_DEN = 4096;

   logic [SUM_W-1:0]  group_sum;
   logic [CNT_W-1:0]  group_count;
   logic [LVL_W-1:0]  last_level;
   logic [BAND_W-1:0] band;
   logic [LVL_W-1:0]  level;
   logic [LVL_W-1:0]  want;
   logic [LVL_W-1:0]  expected_levels[$];
   int                errors = 0;
   int                waiting = 0;

   assign fail_count  = errors;
   assign outstanding = waiting;

   function automatic logic [LVL_W-1:0] percent_of_average(input logic [AVG_W-1:0] avg);
      longint unsigned m;
      longint unsigned q;
      m = avg;
      m = m * 6200;
      if (m > 4200 * MV_DEN)
         return LVL_FULL;
      if (m < 3300 * MV_DEN)
         return LVL_EMPTY;
      if (m > 3650 * MV_DEN) begin
         q = ((m - 3550 * MV_DEN) * 80) / (650 * MV_DEN) + 20;
         return LVL_W'(q);
      end
      q = ((m - 3200 * MV_DEN) * 20) / (450 * MV_DEN);
      return LVL_W'(q);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         group_sum   = '0;
         group_count = '0;
         last_level  = '0;
         band        = HOLD_BAND_RESET;
         expected_levels.delete();
      end else begin
         if (csr_write_enable)
            band = csr_write_data;
         if (req_valid && !req_stall) begin
            group_sum   = group_sum + req_sample;
            group_count = group_count + 1'b1;
            if (group_count == SAMPLES) begin
               level = percent_of_average(AVG_W'(group_sum / SAMPLES));
               if (level > last_level && (level - last_level) < band && last_level != 0)
                  level = last_level;
               last_level = level;
               expected_levels.push_back(level);
               group_sum   = '0;
               group_count = '0;
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_levels.size() == 0) begin
               if (errors < 10)
                  $display("unexpected level item: level_percent=%0d", rsp_level_percent);
               errors++;
            end else begin
               want = expected_levels.pop_front();
               if (rsp_level_percent !== want) begin
                  if (errors < 10)
                     $display("level mismatch: expected %0d, got %0d", want, rsp_level_percent);
                  errors++;
               end
            end
         end
      end
      waiting = expected_levels.size();
   end

endmodule

@@ tb/sv/tb_battery_level_gauge_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_battery_level_gauge_core
// Stimulus and verdict for the battery level gauge.
//
// Sends one directed group of extreme samples, then groups whose samples
// cluster around a slowly wandering target voltage so that both curve
// segments, the clipped ends and the hold band are reached, mixed with
// groups of pure noise. The hold band is rewritten between phases while
// the block is idle. Both channels idle at random except in the last phase.
// ----------------------------------------------------------------------------
module tb_battery_level_gauge_core;
   import blg_pkg::*;

   localparam int SAMPLES      = 20;
   localparam int SETTLE_WAIT  = 16;
   localparam int PHASES       = 6;
   localparam int PHASE_GROUPS = 12;
   localparam int TARGET_LO    = 2100;
   localparam int TARGET_HI    = 2850;

   logic              clock            = 1'b0;
   logic              reset            = 1'b1;
   logic              req_valid        = 1'b0;
   logic              req_stall;
   logic [SMP_W-1:0]  req_sample       = '0;
   logic              rsp_valid;
   logic              rsp_stall        = 1'b0;
   logic [LVL_W-1:0]  rsp_level_percent;
   logic              csr_write_enable = 1'b0;
   logic [BAND_W-1:0] csr_write_data   = '0;

   bit idle_on = 1'b1;
   int fail_count;
   int outstanding;

   always #5 clock = ~clock;

   battery_level_gauge_core #(.SAMPLES(SAMPLES)) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_sample        (req_sample),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_level_percent (rsp_level_percent),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data)
   );

   tb_battery_level_gauge_checker #(.SAMPLES(SAMPLES)) gauge_check (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_sample        (req_sample),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_level_percent (rsp_level_percent),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .fail_count        (fail_count),
      .outstanding       (outstanding)
   );

   task automatic send_sample(input logic [SMP_W-1:0] s);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_sample <= s;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic send_group_near(input int target, input int spread);
      int v;
      for (int i = 0; i < SAMPLES; i++) begin
         v = target + int'($urandom_range(0, spread)) - spread / 2;
         if (v < 0)
            v = 0;
         if (v > 4095)
            v = 4095;
         send_sample(SMP_W'(v));
      end
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE_WAIT) @(posedge clock);
   endtask

   task automatic write_band(input logic [BAND_W-1:0] v);
      csr_write_data   <= v;
      csr_write_enable <= 1'b1;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // hold rsp_ off in random bursts
   initial begin
      forever begin
         @(posedge clock);
         if (idle_on && $urandom_range(0, 4) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 11)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      logic [BAND_W-1:0] bands[PHASES];
      int                target;
      int                pick;

      bands = '{4'd0, 4'd15, 4'd1, 4'd0, 4'd8, 4'd4};
      bands[3] = BAND_W'($urandom_range(0, 15));
      target = 2400;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_sample(12'h000);
      send_sample(12'hFFF);
      send_sample(12'hAAA);
      send_sample(12'h555);
      for (int i = 4; i < SAMPLES; i++)
         send_sample(12'hFFF);
      settle();

      for (int p = 0; p < PHASES; p++) begin
         write_band(bands[p]);
         idle_on = (p < PHASES - 1);
         for (int g = 0; g < PHASE_GROUPS; g++) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
               target = target + int'($urandom_range(0, 60)) - 30;
               if (target < TARGET_LO)
                  target = TARGET_LO;
               if (target > TARGET_HI)
                  target = TARGET_HI;
               send_group_near(target, $urandom_range(0, 48));
            end else if (pick < 85) begin
               target = $urandom_range(TARGET_LO, TARGET_HI);
               send_group_near(target, $urandom_range(0, 48));
            end else begin
               for (int i = 0; i < SAMPLES; i++)
                  send_sample(SMP_W'($urandom_range(0, 4095)));
            end
         end
         // leave a partial group in the accumulator now and then
         if ($urandom_range(0, 1) == 0)
            repeat ($urandom_range(1, SAMPLES - 1))
               send_sample(SMP_W'($urandom_range(0, 4095)));
         settle();
      end

      if (outstanding != 0)
         $display("%0d level items never arrived", outstanding);
      if (fail_count == 0 && outstanding == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      #4000000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
